>>> rtl/gmps_pkg.sv
// gmps_pkg: shared types and constants of the grid maze path search unit.
// Cell and direction codes, command codes and default grid dimensions.
// No dependencies.
package gmps_pkg;

    localparam int GRID_ROWS_DEF = 16;
    localparam int GRID_COLS_DEF = 16;
    localparam int COORD_W       = 4;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [1:0]         cell_t;
    typedef logic [1:0]         dir_t;

    // cell state codes
    localparam cell_t CELL_WALL = 2'd0;
    localparam cell_t CELL_OPEN = 2'd1;
    localparam cell_t CELL_SEEN = 2'd2;

    // neighbor probe order
    localparam dir_t DIR_SOUTH = 2'd0;
    localparam dir_t DIR_WEST  = 2'd1;
    localparam dir_t DIR_NORTH = 2'd2;
    localparam dir_t DIR_EAST  = 2'd3;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;

endpackage

>>> rtl/gmps_ram.sv
// gmps_ram: generic simple dual-port RAM, one write and one registered read.
// Used for the cell grid and the search stack. No dependencies.
module gmps_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/grid_maze_path_search_unit.sv
// grid_maze_path_search_unit: cell grid with a depth-first path search engine.
// Depends on gmps_pkg and gmps_ram (grid memory and search stack memory).

// A write item sets one grid cell open or wall and gives no result;
// writes outside the grid are dropped. A solve item runs a depth-first search
// (neighbor order south, west, north, east) from the start cell and gives one
// path_found item. Cells entered by a search stay marked visited until written
// again. Each neighbor probe is an address step (ST_STEP) followed by a check and
// update step (ST_CHECK), and each return to a frame held in the stack memory
// adds a reload step (ST_LOAD); a solve ends early when the goal is reached.
// After reset the block clears the grid to walls, one entry per cycle, over
// GRID_ROWS * 2**ceil(log2(GRID_COLS)) entries (256 for a 16 x 16 grid) before
// in_ready first rises. A pending result does not block write items.
module grid_maze_path_search_unit #(
    parameter int GRID_ROWS = gmps_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = gmps_pkg::GRID_COLS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            command,
    input  gmps_pkg::coord_t cell_row,
    input  gmps_pkg::coord_t cell_col,
    input  logic            cell_open,
    input  gmps_pkg::coord_t start_row,
    input  gmps_pkg::coord_t start_col,
    input  gmps_pkg::coord_t end_row,
    input  gmps_pkg::coord_t end_col,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            path_found
);

    import gmps_pkg::*;

    localparam int RW     = $clog2(GRID_ROWS);
    localparam int CW     = $clog2(GRID_COLS);
    localparam int AW     = RW + CW;
    localparam int GDEPTH = GRID_ROWS * (2 ** CW);
    localparam int NCELLS = GRID_ROWS * GRID_COLS;
    localparam int SW     = $clog2(NCELLS);
    localparam int DW     = $clog2(NCELLS + 1);
    localparam int FW     = AW + 2;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_STEP   = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_LOAD   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] top_cell_reg, top_cell_next;
    dir_t          top_dir_reg, top_dir_next;
    logic          top_valid_reg, top_valid_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [AW-1:0] nb_reg, nb_next;
    logic [AW-1:0] end_cell_reg, end_cell_next;
    logic          end_ok_reg, end_ok_next;
    logic          found_reg, found_next;
    logic          out_valid_reg, out_valid_next;
    logic          path_found_reg, path_found_next;

    // grid memory ports
    logic          g_we;
    logic [AW-1:0] g_waddr;
    cell_t         g_wdata;
    logic [AW-1:0] g_raddr;
    cell_t         g_rdata;

    // stack memory ports
    logic          s_we;
    logic [SW-1:0] s_waddr;
    logic [FW-1:0] s_wdata;
    logic [SW-1:0] s_raddr;
    logic [FW-1:0] s_rdata;

    logic [RW-1:0] top_r;
    logic [CW-1:0] top_c;
    logic [AW-1:0] nb_cell;
    logic          nb_inside;
    logic          accept;
    logic          cell_in_grid;
    logic          start_in_grid;
    logic          end_in_grid;
    logic          hit;
    logic          mark;
    logic          push;

    assign accept        = in_valid && in_ready;
    assign cell_in_grid  = (32'(cell_row) < GRID_ROWS) && (32'(cell_col) < GRID_COLS);
    assign start_in_grid = (32'(start_row) < GRID_ROWS) && (32'(start_col) < GRID_COLS);
    assign end_in_grid   = (32'(end_row) < GRID_ROWS) && (32'(end_col) < GRID_COLS);

    assign top_r = top_cell_reg[AW-1:CW];
    assign top_c = top_cell_reg[CW-1:0];

    // neighbor of the top frame in its current probe direction
    always_comb
    begin
        nb_cell   = top_cell_reg;
        nb_inside = 1'b0;
        case (top_dir_reg)
            DIR_SOUTH:
            begin
                nb_inside = (top_r != RW'(GRID_ROWS - 1));
                nb_cell   = {top_r + RW'(1), top_c};
            end
            DIR_WEST:
            begin
                nb_inside = (top_c != '0);
                nb_cell   = {top_r, top_c - CW'(1)};
            end
            DIR_NORTH:
            begin
                nb_inside = (top_r != '0);
                nb_cell   = {top_r - RW'(1), top_c};
            end
            default:
            begin
                nb_inside = (top_c != CW'(GRID_COLS - 1));
                nb_cell   = {top_r, top_c + CW'(1)};
            end
        endcase
    end

    assign hit  = (g_rdata == CELL_OPEN) && end_ok_reg && (nb_reg == end_cell_reg);
    assign mark = (g_rdata == CELL_OPEN) && !hit;
    assign push = mark && (depth_reg != DW'(NCELLS));

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        top_cell_next   = top_cell_reg;
        top_dir_next    = top_dir_reg;
        top_valid_next  = top_valid_reg;
        depth_next      = depth_reg;
        nb_next         = nb_reg;
        end_cell_next   = end_cell_reg;
        end_ok_next     = end_ok_reg;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        path_found_next = path_found_reg;

        g_we    = 1'b0;
        g_waddr = nb_reg;
        g_wdata = CELL_SEEN;
        g_raddr = nb_cell;
        s_we    = 1'b0;
        s_waddr = SW'(depth_reg - DW'(1));
        s_wdata = {top_cell_reg, top_dir_reg};
        s_raddr = SW'(depth_reg - DW'(1));

        unique case (state_reg)
            ST_CLEAR:
            begin
                g_we     = 1'b1;
                g_waddr  = clr_reg;
                g_wdata  = CELL_WALL;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(GDEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_WRITE)
                    begin
                        g_we    = cell_in_grid;
                        g_waddr = {RW'(cell_row), CW'(cell_col)};
                        g_wdata = cell_open ? CELL_OPEN : CELL_WALL;
                    end
                    else if ((start_row == end_row) && (start_col == end_col))
                    begin
                        found_next = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else if (!start_in_grid)
                    begin
                        found_next = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        g_we           = 1'b1;
                        g_waddr        = {RW'(start_row), CW'(start_col)};
                        g_wdata        = CELL_SEEN;
                        top_cell_next  = {RW'(start_row), CW'(start_col)};
                        top_dir_next   = DIR_SOUTH;
                        top_valid_next = 1'b1;
                        depth_next     = DW'(1);
                        end_cell_next  = {RW'(end_row), CW'(end_col)};
                        end_ok_next    = end_in_grid;
                        state_next     = ST_STEP;
                    end
                end
            end
            ST_STEP:
            begin
                // the east probe is the frame's last, so it leaves the stack now
                if (top_dir_reg == DIR_EAST)
                begin
                    depth_next     = depth_reg - DW'(1);
                    top_valid_next = 1'b0;
                end
                else
                begin
                    top_dir_next = top_dir_reg + 2'd1;
                end
                nb_next = nb_cell;
                if (nb_inside)
                begin
                    state_next = ST_CHECK;
                end
                else if (top_dir_reg == DIR_EAST)
                begin
                    if (depth_reg == DW'(1))
                    begin
                        found_next = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        s_raddr    = SW'(depth_reg - DW'(2));
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_CHECK:
            begin
                g_we = mark;
                if (hit)
                begin
                    found_next = 1'b1;
                    depth_next = '0;
                    state_next = ST_FINISH;
                end
                else if (push)
                begin
                    // spill the current top frame only if it is still held here
                    s_we           = top_valid_reg;
                    top_cell_next  = nb_reg;
                    top_dir_next   = DIR_SOUTH;
                    top_valid_next = 1'b1;
                    depth_next     = depth_reg + DW'(1);
                    state_next     = ST_STEP;
                end
                else if (top_valid_reg)
                begin
                    state_next = ST_STEP;
                end
                else if (depth_reg == '0)
                begin
                    found_next = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                top_cell_next  = s_rdata[FW-1:2];
                top_dir_next   = s_rdata[1:0];
                top_valid_next = 1'b1;
                state_next     = ST_STEP;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    path_found_next = found_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            top_valid_reg <= 1'b0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            top_valid_reg <= top_valid_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_cell_reg   <= top_cell_next;
        top_dir_reg    <= top_dir_next;
        nb_reg         <= nb_next;
        end_cell_reg   <= end_cell_next;
        end_ok_reg     <= end_ok_next;
        found_reg      <= found_next;
        path_found_reg <= path_found_next;
    end

    gmps_ram #(
        .WIDTH (2),
        .DEPTH (GDEPTH)
    ) u_grid_ram (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    gmps_ram #(
        .WIDTH (FW),
        .DEPTH (NCELLS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign path_found = path_found_reg;

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(NCELLS))
        else $error("stack depth beyond grid size");

    a_step_top_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STEP |-> top_valid_reg)
        else $error("probe issued without a held top frame");

    a_check_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> $past(state_reg) == ST_STEP)
        else $error("grid check without a preceding probe");

    a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |-> depth_reg != '0 && !top_valid_reg)
        else $error("stack reload from an empty stack");
`endif

endmodule
